FILE: hw/rtl/kdar_pkg.sv
// ----------------------------------------------------------------------------
// kdar_pkg
// Shared types and constants for the key debounce and auto-repeat block.
// ----------------------------------------------------------------------------
package kdar_pkg;

    // key count limits
    localparam int NUM_KEYS_DEF = 2;
    localparam int MAX_KEYS     = 2;

    // field widths
    localparam int LEVELS_W   = 2;
    localparam int NOW_W      = 63;
    localparam int CNT_W      = 4;
    localparam int TIME_CFG_W = 32;
    localparam int CODE_W     = 8;

    // apb port
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 5;
    localparam int REG_IDX_W  = 3;

    // result queue
    localparam int FIFO_DEPTH  = 4;
    localparam int MAX_RESULTS = 2;

    // register reset values
    localparam logic [CNT_W-1:0]      DEBOUNCE_RST = 4'd2;
    localparam logic [TIME_CFG_W-1:0] DELAY_RST    = 32'd450000;
    localparam logic [TIME_CFG_W-1:0] INTERVAL_RST = 32'd200000;
    localparam logic [CODE_W-1:0]     CODE0_RST    = 8'd38;
    localparam logic [CODE_W-1:0]     CODE1_RST    = 8'd40;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_DEBOUNCE = 3'd0,
        REG_DELAY    = 3'd1,
        REG_INTERVAL = 3'd2,
        REG_CODE0    = 3'd3,
        REG_CODE1    = 3'd4
    } kdar_reg_e_t;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              index;
        logic              last;
    } kdar_evt_t;

endpackage

FILE: hw/rtl/key_debounce_autorepeat_top.sv
// ----------------------------------------------------------------------------
// key_debounce_autorepeat_top
// Debouncer for up to two active-low keys with typematic auto-repeat.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one poll per beat: raw_levels
//   (bit k is key k, 0 = pressed) and the microsecond timestamp now_us.
//   Output channel (out_valid / out_stall) carries one event per beat:
//   key_code, key_index and last, which marks the final event of a poll.
//   A poll produces zero, one or two events, key zero first.
//   Key state updates at the accepting edge; its events enter a four-entry
//   result queue at the same edge and leave it in order behind older events.
//   Polls are accepted every cycle while the queue has room for two events,
//   so throughput is one poll per cycle; a poll with two events uses two
//   output beats, which bounds the sustained rate when both keys fire.
//   When the receiver stalls, queued events hold and in_stall rises once
//   fewer than two free entries remain.
//   Registers are written over the apb port (index 4*i, pready always high)
//   and should only change while no poll is in flight.
//   Reset empties the queue, releases all keys, clears mismatch counts and
//   timestamps, and loads the register defaults.
// ----------------------------------------------------------------------------
module key_debounce_autorepeat_top #(
    parameter int NUM_KEYS = kdar_pkg::NUM_KEYS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // poll channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [kdar_pkg::LEVELS_W-1:0]       raw_levels,
    input  logic [kdar_pkg::NOW_W-1:0]          now_us,
    // event channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [kdar_pkg::CODE_W-1:0]         key_code,
    output logic                                key_index,
    output logic                                last,
    // apb
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [kdar_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [kdar_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [kdar_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import kdar_pkg::*;

    localparam int KeysUsed  = (NUM_KEYS < MAX_KEYS) ? NUM_KEYS : MAX_KEYS;
    localparam int FifoDepth = FIFO_DEPTH;
    localparam int PtrW      = $clog2(FifoDepth);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [CNT_W-1:0]      debounce_reg;
    logic [TIME_CFG_W-1:0] delay_reg;
    logic [TIME_CFG_W-1:0] interval_reg;
    logic [CODE_W-1:0]     code0_reg;
    logic [CODE_W-1:0]     code1_reg;
    logic                  cfg_wr;
    kdar_reg_e_t           reg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = kdar_reg_e_t'(paddr[APB_ADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= DEBOUNCE_RST;
            delay_reg    <= DELAY_RST;
            interval_reg <= INTERVAL_RST;
            code0_reg    <= CODE0_RST;
            code1_reg    <= CODE1_RST;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_DEBOUNCE: debounce_reg <= pwdata[CNT_W-1:0];
                REG_DELAY:    delay_reg    <= pwdata[TIME_CFG_W-1:0];
                REG_INTERVAL: interval_reg <= pwdata[TIME_CFG_W-1:0];
                REG_CODE0:    code0_reg    <= pwdata[CODE_W-1:0];
                REG_CODE1:    code1_reg    <= pwdata[CODE_W-1:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_DEBOUNCE: prdata = APB_DATA_W'(debounce_reg);
            REG_DELAY:    prdata = APB_DATA_W'(delay_reg);
            REG_INTERVAL: prdata = APB_DATA_W'(interval_reg);
            REG_CODE0:    prdata = APB_DATA_W'(code0_reg);
            REG_CODE1:    prdata = APB_DATA_W'(code1_reg);
            default:      prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // per-key debounce and repeat
    // ------------------------------------------------------------------
    logic                  in_acc;
    logic                  stable_reg [KeysUsed];
    logic [CNT_W-1:0]      mism_reg   [KeysUsed];
    logic [NOW_W-1:0]      press_reg  [KeysUsed];
    logic [NOW_W-1:0]      last_reg   [KeysUsed];
    logic                  ev         [KeysUsed];

    assign in_acc = in_valid && !in_stall;

    for (genvar k = 0; k < KeysUsed; k++)
    begin : g_key
        logic             raw_pressed;
        logic [CNT_W:0]   cnt_inc;
        logic [NOW_W:0]   since_press;
        logic [NOW_W:0]   since_last;
        logic             delay_ok;
        logic             interval_ok;
        logic             stable_next;
        logic [CNT_W-1:0] mism_next;
        logic [NOW_W-1:0] press_next;
        logic [NOW_W-1:0] last_next;

        assign raw_pressed = ~raw_levels[k];
        assign cnt_inc     = {1'b0, mism_reg[k]} + (CNT_W+1)'(1);
        // signed elapsed time: top bit set means the clock went backwards
        assign since_press = {1'b0, now_us} - {1'b0, press_reg[k]};
        assign since_last  = {1'b0, now_us} - {1'b0, last_reg[k]};
        assign delay_ok    = !since_press[NOW_W] &&
            (since_press[NOW_W-1:0] >= {{(NOW_W-TIME_CFG_W){1'b0}}, delay_reg});
        assign interval_ok = !since_last[NOW_W] &&
            (since_last[NOW_W-1:0] >= {{(NOW_W-TIME_CFG_W){1'b0}}, interval_reg});

        always_comb
        begin
            stable_next = stable_reg[k];
            mism_next   = mism_reg[k];
            press_next  = press_reg[k];
            last_next   = last_reg[k];
            ev[k]       = 1'b0;
            if (raw_pressed != stable_reg[k])
            begin
                // a limit of zero behaves like one
                if (cnt_inc < {1'b0, debounce_reg})
                begin
                    mism_next = cnt_inc[CNT_W-1:0];
                end
                else
                begin
                    mism_next   = '0;
                    stable_next = raw_pressed;
                    if (raw_pressed)
                    begin
                        press_next = now_us;
                        last_next  = now_us;
                        ev[k]      = 1'b1;
                    end
                end
            end
            else
            begin
                mism_next = '0;
                if (stable_reg[k] && delay_ok && interval_ok)
                begin
                    last_next = now_us;
                    ev[k]     = 1'b1;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                stable_reg[k] <= 1'b0;
                mism_reg[k]   <= '0;
                press_reg[k]  <= '0;
                last_reg[k]   <= '0;
            end
            else if (in_acc)
            begin
                stable_reg[k] <= stable_next;
                mism_reg[k]   <= mism_next;
                press_reg[k]  <= press_next;
                last_reg[k]   <= last_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // result queue
    // ------------------------------------------------------------------
    logic            ev0;
    logic            ev1;
    kdar_evt_t       evt0;
    kdar_evt_t       evt1;
    kdar_evt_t       slot0;
    logic            push0;
    logic            push1;
    logic            out_acc;
    logic [PtrW:0]   n_push;
    kdar_evt_t       fifo_mem [FifoDepth];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [PtrW-1:0] rd_ptr_next;
    logic [PtrW:0]   cnt_reg;
    logic [PtrW:0]   cnt_next;

    assign ev0 = ev[0];
    assign ev1 = (KeysUsed > 1) ? ev[KeysUsed-1] : 1'b0;

    assign evt0  = '{code: code0_reg, index: 1'b0, last: !ev1};
    assign evt1  = '{code: code1_reg, index: 1'b1, last: 1'b1};
    assign slot0 = ev0 ? evt0 : evt1;

    assign push0   = in_acc && (ev0 || ev1);
    assign push1   = in_acc && ev0 && ev1;
    assign out_acc = out_valid && !out_stall;
    assign n_push  = (PtrW+1)'(push0) + (PtrW+1)'(push1);

    assign wr_ptr_next = wr_ptr_reg + n_push[PtrW-1:0];
    assign rd_ptr_next = rd_ptr_reg + PtrW'(out_acc);
    assign cnt_next    = cnt_reg + n_push - (PtrW+1)'(out_acc);

    // room for a two-event poll is required before a beat is taken
    assign in_stall  = cnt_reg > (PtrW+1)'(FifoDepth - MAX_RESULTS);
    assign out_valid = cnt_reg != '0;
    assign key_code  = fifo_mem[rd_ptr_reg].code;
    assign key_index = fifo_mem[rd_ptr_reg].index;
    assign last      = fifo_mem[rd_ptr_reg].last;

    always_ff @(posedge clk)
    begin
        if (push0)
        begin
            fifo_mem[wr_ptr_reg] <= slot0;
        end
        if (push1)
        begin
            fifo_mem[wr_ptr_reg + PtrW'(1)] <= evt1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
`ifndef ASSERT_OFF
    a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (PtrW+1)'(FifoDepth))
        else $error("result queue overflow");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_ptr_reg - rd_ptr_reg) == cnt_reg[PtrW-1:0])
        else $error("queue pointers disagree with fill count");

    for (genvar k = 0; k < KeysUsed; k++)
    begin : g_key_chk
        a_mism_bound: assert property (@(posedge clk) disable iff (!rst_n)
            mism_reg[k] != {CNT_W{1'b1}})
            else $error("mismatch count reached its ceiling");

        a_event_held: assert property (@(posedge clk) disable iff (!rst_n)
            (in_acc && ev[k]) |=> stable_reg[k])
            else $error("event emitted for a key that is not held");

        a_time_order: assert property (@(posedge clk) disable iff (!rst_n)
            last_reg[k] >= press_reg[k])
            else $error("last event time precedes press time");
    end
`endif

endmodule

FILE: tb/kdar_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdar_checker
// Watches the poll, event and apb channels of the key debouncer, keeps its
// own copy of the per-key state and registers, predicts the events of every
// accepted poll and compares each accepted event with the oldest prediction.
// ----------------------------------------------------------------------------
module kdar_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  logic [kdar_pkg::LEVELS_W-1:0]       raw_levels,
    input  logic [kdar_pkg::NOW_W-1:0]          now_us,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic [kdar_pkg::CODE_W-1:0]         key_code,
    input  logic                                key_index,
    input  logic                                last,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic                                pready,
    input  logic [kdar_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [kdar_pkg::APB_DATA_W-1:0]     pwdata,
    output int                                  error_count,
    output int                                  pending,
    output int                                  polls_seen,
    output int                                  events_seen
);
    import kdar_pkg::*;

    // register copy
    logic [CNT_W-1:0]      db_limit;
    logic [TIME_CFG_W-1:0] delay_us;
    logic [TIME_CFG_W-1:0] interval_us;
    logic [CODE_W-1:0]     code0;
    logic [CODE_W-1:0]     code1;

    // per-key state
    logic              key_held    [MAX_KEYS];
    logic [CNT_W-1:0]  bounce_cnt  [MAX_KEYS];
    logic [NOW_W-1:0]  press_stamp [MAX_KEYS];
    logic [NOW_W-1:0]  event_stamp [MAX_KEYS];

    kdar_evt_t key_events_q[$];

    task automatic clear_model();
        db_limit    = DEBOUNCE_RST;
        delay_us    = DELAY_RST;
        interval_us = INTERVAL_RST;
        code0       = CODE0_RST;
        code1       = CODE1_RST;
        for (int k = 0; k < MAX_KEYS; k++)
        begin
            key_held[k]    = 1'b0;
            bounce_cnt[k]  = '0;
            press_stamp[k] = '0;
            event_stamp[k] = '0;
        end
        key_events_q.delete();
    endtask

    // signed microseconds between two stamps
    function automatic longint us_since(logic [NOW_W-1:0] from, logic [NOW_W-1:0] to);
        return $signed({1'b0, to}) - $signed({1'b0, from});
    endfunction

    // debounce one key and say whether it emits a key-down or repeat
    function automatic logic key_fires(int k, logic pressed, logic [NOW_W-1:0] now);
        int unsigned next_cnt;
        if (pressed != key_held[k])
        begin
            next_cnt = bounce_cnt[k] + 1;
            if (next_cnt < db_limit)
            begin
                bounce_cnt[k] = next_cnt[CNT_W-1:0];
                return 1'b0;
            end
            bounce_cnt[k] = '0;
            key_held[k]   = pressed;
            if (pressed)
            begin
                press_stamp[k] = now;
                event_stamp[k] = now;
                return 1'b1;
            end
            return 1'b0;
        end
        bounce_cnt[k] = '0;
        if (!key_held[k])
            return 1'b0;
        if (us_since(press_stamp[k], now) < longint'({32'b0, delay_us}))
            return 1'b0;
        if (us_since(event_stamp[k], now) < longint'({32'b0, interval_us}))
            return 1'b0;
        event_stamp[k] = now;
        return 1'b1;
    endfunction

    task automatic predict_poll(logic [LEVELS_W-1:0] levels, logic [NOW_W-1:0] now);
        kdar_evt_t evs [MAX_RESULTS];
        int        n;
        n = 0;
        for (int k = 0; k < MAX_KEYS; k++)
        begin
            if (key_fires(k, !levels[k], now))
            begin
                evs[n].code  = (k == 0) ? code0 : code1;
                evs[n].index = k[0];
                evs[n].last  = 1'b0;
                n++;
            end
        end
        for (int i = 0; i < n; i++)
        begin
            evs[i].last = (i == n - 1);
            key_events_q.push_back(evs[i]);
        end
    endtask

    task automatic report(string what, longint want, longint got);
        error_count++;
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        kdar_evt_t want;
        if (!rst_n)
        begin
            clear_model();
            error_count = 0;
            polls_seen  = 0;
            events_seen = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (kdar_reg_e_t'(paddr[APB_ADDR_W-1:2]))
                    REG_DEBOUNCE: db_limit    = pwdata[CNT_W-1:0];
                    REG_DELAY:    delay_us    = pwdata[TIME_CFG_W-1:0];
                    REG_INTERVAL: interval_us = pwdata[TIME_CFG_W-1:0];
                    REG_CODE0:    code0       = pwdata[CODE_W-1:0];
                    REG_CODE1:    code1       = pwdata[CODE_W-1:0];
                    default: ;
                endcase
            end
            // events leave only after their poll has been queued, so compare before predicting
            if (out_valid && !out_stall)
            begin
                events_seen++;
                if (key_events_q.size() == 0)
                begin
                    report("unexpected event key_code", -1, longint'(key_code));
                end
                else
                begin
                    want = key_events_q.pop_front();
                    if (key_code !== want.code)
                        report("key_code", longint'(want.code), longint'(key_code));
                    if (key_index !== want.index)
                        report("key_index", longint'(want.index), longint'(key_index));
                    if (last !== want.last)
                        report("last", longint'(want.last), longint'(last));
                end
            end
            if (in_valid && !in_stall)
            begin
                polls_seen++;
                predict_poll(raw_levels, now_us);
            end
        end
        pending = key_events_q.size();
    end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the key debouncer: directed press, hold, release and time
// jump polls, then random bouncing key sequences under several register
// settings with random idling on both channels; the checker does the scoring.
// ----------------------------------------------------------------------------
module testbench;
    import kdar_pkg::*;

    localparam int STALL_LIMIT = 5000;
    localparam int PHASE_POLLS = 100;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    logic [LEVELS_W-1:0]    raw_levels;
    logic [NOW_W-1:0]       now_us;
    logic                   out_valid;
    logic                   out_stall;
    logic [CODE_W-1:0]      key_code;
    logic                   key_index;
    logic                   last;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [APB_ADDR_W-1:0]  paddr;
    logic [APB_DATA_W-1:0]  pwdata;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    int error_count;
    int pending;
    int polls_seen;
    int events_seen;
    int settings_used;
    int idle_cycles;
    bit quiet;

    // random key sequence state
    logic [NOW_W-1:0] stamp;
    logic             want_pressed [MAX_KEYS];
    int               run_left     [MAX_KEYS];
    int               db_now;

    key_debounce_autorepeat_top u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .raw_levels (raw_levels),
        .now_us     (now_us),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .key_code   (key_code),
        .key_index  (key_index),
        .last       (last),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    kdar_checker u_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .raw_levels  (raw_levels),
        .now_us      (now_us),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .key_code    (key_code),
        .key_index   (key_index),
        .last        (last),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .error_count (error_count),
        .pending     (pending),
        .polls_seen  (polls_seen),
        .events_seen (events_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // receiver side stalls in bursts
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            if (!quiet && $urandom_range(0, 2) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            out_stall <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge clk);
        end
    end

    // watchdog on cycles without any beat
    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("key_debounce_autorepeat_top verification failed");
        $finish;
    end

    task automatic apb_write(kdar_reg_e_t idx, logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // wait until every predicted event has left the block
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_regs(int db, logic [31:0] dly, logic [31:0] ivl,
                            logic [7:0] c0, logic [7:0] c1);
        drain();
        apb_write(REG_DEBOUNCE, APB_DATA_W'(db));
        apb_write(REG_DELAY, dly);
        apb_write(REG_INTERVAL, ivl);
        apb_write(REG_CODE0, APB_DATA_W'(c0));
        apb_write(REG_CODE1, APB_DATA_W'(c1));
        @(posedge clk);
        db_now = db;
        settings_used++;
    endtask

    task automatic send_poll(logic [LEVELS_W-1:0] lv, logic [NOW_W-1:0] t);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        raw_levels <= lv;
        now_us     <= t;
        do @(posedge clk); while (in_stall);
    endtask

    // bouncing key runs with random content, plus noise and time jumps
    task automatic run_phase(int n, longint unsigned step_max);
        logic [LEVELS_W-1:0] lv;
        longint unsigned     rnd;
        int                  eff;
        int                  r;
        eff = (db_now == 0) ? 1 : db_now;
        for (int i = 0; i < n; i++)
        begin
            for (int k = 0; k < MAX_KEYS; k++)
            begin
                if (run_left[k] <= 0)
                begin
                    want_pressed[k] = !want_pressed[k];
                    if ($urandom_range(0, 4) == 0)
                        run_left[k] = $urandom_range(1, eff);
                    else
                        run_left[k] = $urandom_range(eff, 3 * eff + 20);
                end
                run_left[k]--;
                lv[k] = !want_pressed[k];
                if ($urandom_range(0, 11) == 0)
                    lv[k] = !lv[k];
            end
            if ($urandom_range(0, 9) == 0)
                lv = LEVELS_W'($urandom_range(0, 3));
            rnd = {$urandom, $urandom};
            r   = $urandom_range(0, 99);
            if (r < 2)
                stamp = rnd[NOW_W-1:0];
            else if (r < 5)
                stamp = stamp - NOW_W'(rnd % (step_max + 1));
            else
                stamp = stamp + NOW_W'(rnd % (step_max + 1));
            send_poll(lv, stamp);
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        raw_levels = 2'b11;
        now_us     = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        quiet      = 1'b0;
        stamp      = '0;
        db_now     = int'(DEBOUNCE_RST);
        settings_used = 1;
        for (int k = 0; k < MAX_KEYS; k++)
        begin
            want_pressed[k] = 1'b0;
            run_left[k]     = 0;
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset defaults: press, hold into repeat, release, both keys
        send_poll(2'b11, 63'd0);
        send_poll(2'b10, 63'd100000);
        send_poll(2'b10, 63'd200000);
        send_poll(2'b10, 63'd400000);
        send_poll(2'b10, 63'd650000);
        send_poll(2'b10, 63'd700000);
        send_poll(2'b10, 63'd850000);
        // time going backwards while held
        send_poll(2'b10, 63'd100000);
        // single glitch that does not release
        send_poll(2'b11, 63'd900000);
        send_poll(2'b10, 63'd950000);
        // release emits nothing
        send_poll(2'b11, 63'd1000000);
        send_poll(2'b11, 63'd1100000);
        // both keys at once give two events in one poll
        send_poll(2'b00, 63'd1900000);
        send_poll(2'b00, 63'd2000000);
        send_poll(2'b00, 63'd2450000);
        send_poll(2'b00, 63'd2650000);
        send_poll(2'b10, 63'd2700000);
        send_poll(2'b10, 63'd2800000);
        // timestamp extremes
        send_poll(2'b00, {NOW_W{1'b1}});
        send_poll(2'b00, {NOW_W{1'b1}});
        send_poll(2'b00, 63'd0);
        send_poll(2'b11, 63'd5);
        send_poll(2'b11, 63'd10);

        // register extremes
        set_regs(1, 32'd0, 32'd0, 8'd0, 8'd255);
        run_phase(PHASE_POLLS, 64'd20);
        set_regs(15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd255, 8'd0);
        run_phase(PHASE_POLLS, 64'h1_0000_0000);
        // zero debounce limit acts like one
        set_regs(0, 32'd5, 32'd3, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        run_phase(PHASE_POLLS, 64'd6);
        for (int p = 0; p < 5; p++)
        begin
            set_regs($urandom_range(0, 3) == 0 ? $urandom_range(0, 15) : $urandom_range(0, 4),
                     $urandom_range(0, 300), $urandom_range(0, 150),
                     8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            if (p == 4)
                quiet = 1'b1;
            run_phase(PHASE_POLLS, 64'd60);
        end

        drain();
        repeat (8) @(posedge clk);
        $display("run covered %0d polls and %0d events over %0d register settings",
                 polls_seen, events_seen, settings_used);
        $display("with bouncing keys, zero and maximal debounce, time jumps and idle bursts");
        if (error_count == 0)
            $display("key_debounce_autorepeat_top verification clean");
        else
            $display("key_debounce_autorepeat_top verification failed");
        $finish;
    end

endmodule
